/* rtl/core/transaction_id_remap_table_assert.svh */
// Assertion macros used by the remap table checker.
// No dependencies; include by bare file name.
`ifndef TRANSACTION_ID_REMAP_TABLE_ASSERT_SVH
`define TRANSACTION_ID_REMAP_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TIDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define TIDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tidr_pkg.sv */
// Shared types and constants for the transaction ident remap table.
// No dependencies.
package tidr_pkg;

  localparam int SLOT_COUNT = 512;
  localparam int IDENT_W    = 16;
  localparam int IDX_W      = 9;   // slot index carried in ident bits 8..0
  localparam int RAND_W     = IDENT_W - IDX_W;
  localparam int MAX_SLOTS  = 1 << IDX_W;
  localparam int USED_SLOTS = (SLOT_COUNT < MAX_SLOTS) ? SLOT_COUNT : MAX_SLOTS;
  localparam int SLOT_W     = $clog2(USED_SLOTS);

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic {
    REQ_QUERY    = 1'b0,
    REQ_RESPONSE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_FORWARDED = 2'd0,
    STATUS_MATCHED   = 2'd1,
    STATUS_DROPPED   = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [IDENT_W-1:0]  txn_ident;
    logic [31:0]         client_addr;
    logic [15:0]         client_port;
    logic [RAND_W-1:0]   random_high;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [IDENT_W-1:0]  ident_out;
    logic [31:0]         dest_addr;
    logic [15:0]         dest_port;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [RAND_W-1:0]   rnd;
    logic [IDENT_W-1:0]  local_ident;
    logic [31:0]         client_addr;
    logic [15:0]         client_port;
  } entry_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    entry_t    data;
  } ram_wr_t;

  typedef struct packed {
    slot_idx_t slot;     // slot the next query takes
    logic      wrapped;  // every slot written at least once since reset
  } alloc_t;

endpackage

/* rtl/core/transaction_id_remap_table.sv */
// Transaction ident remap table, top level.
// Depends on tidr_pkg, tidr_alloc, tidr_slot_ram.
//
//  Channel   Handshake               Payload               Direction
//  --------  ----------------------  --------------------  ---------
//  request   start && !busy          tidr_pkg::request_t   in
//  result    done (one-cycle pulse)  tidr_pkg::result_t    out
//
// Timing: a query's result is registered and strobes in the cycle after it is
// accepted; the block can take another transaction in that same cycle. A
// response first reads its slot, then compares and writes back in the lookup
// state, as the slot memory's read data is registered; busy is high for the lookup.
// Reset: synchronous, active high. Clears the allocator and control state;
// no clearing pass, the slot memory is usable right away.
// Stalls: the receiver cannot stall; each result is shown for one cycle.
module transaction_id_remap_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tidr_pkg::request_t  request,
  output logic                done,
  output tidr_pkg::result_t   result
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t              state;
  tidr_pkg::alloc_t    alloc;
  tidr_pkg::ram_wr_t   ram_wr;
  tidr_pkg::entry_t    rd_data;
  tidr_pkg::result_t   result_next;
  tidr_pkg::slot_idx_t rd_addr;

  // Response context held across the memory read.
  logic [tidr_pkg::IDENT_W-1:0] resp_ident;
  logic                         resp_in_range;
  logic                         resp_written;

  logic                         accept;
  logic                         is_query;
  logic                         rd_en;
  logic                         in_range;
  logic                         written;
  logic                         match;
  logic [tidr_pkg::IDX_W:0]     idx_ext;

  assign accept   = start && !busy;
  assign is_query = (request.req_type == tidr_pkg::REQ_QUERY);
  assign rd_en    = accept && !is_query;
  assign rd_addr  = request.txn_ident[tidr_pkg::SLOT_W-1:0];

  // Index field may name a slot beyond the table when it is smaller than 512.
  assign idx_ext  = {1'b0, request.txn_ident[tidr_pkg::IDX_W-1:0]};
  assign in_range = idx_ext < (tidr_pkg::IDX_W + 1)'(tidr_pkg::USED_SLOTS);

  // Slots are filled in order from zero after reset, so anything at or past
  // the allocator has never been written until it wraps once.
  assign written  = alloc.wrapped || (rd_addr < alloc.slot);

  assign match = resp_in_range && resp_written && rd_data.valid &&
                 (rd_data.rnd == resp_ident[tidr_pkg::IDENT_W-1:tidr_pkg::IDX_W]);

  tidr_alloc u_alloc (
    .clk     (clk),
    .rst     (rst),
    .advance (accept && is_query),
    .alloc   (alloc)
  );

  tidr_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Memory writes: a query claims its slot at accept; a matched response
  // clears the valid mark at the end of the lookup. busy keeps a new read
  // from overlapping the write-back, so no forwarding path is needed.
  always_comb begin
    ram_wr = '0;
    unique case (state)
      ST_IDLE: begin
        ram_wr.en                = accept && is_query;
        ram_wr.addr              = alloc.slot;
        ram_wr.data.valid        = 1'b1;
        ram_wr.data.rnd          = request.random_high;
        ram_wr.data.local_ident  = request.txn_ident;
        ram_wr.data.client_addr  = request.client_addr;
        ram_wr.data.client_port  = request.client_port;
      end
      ST_LOOKUP: begin
        ram_wr.en         = match;
        ram_wr.addr       = resp_ident[tidr_pkg::SLOT_W-1:0];
        ram_wr.data       = rd_data;
        ram_wr.data.valid = 1'b0;
      end
      default: ram_wr = '0;
    endcase
  end

  // Result formatting.
  always_comb begin
    result_next = '0;
    unique case (state)
      ST_IDLE: begin
        result_next.status    = tidr_pkg::STATUS_FORWARDED;
        result_next.ident_out = {request.random_high, tidr_pkg::IDX_W'(alloc.slot)};
      end
      ST_LOOKUP: begin
        if (match) begin
          result_next.status    = tidr_pkg::STATUS_MATCHED;
          result_next.ident_out = rd_data.local_ident;
          result_next.dest_addr = rd_data.client_addr;
          result_next.dest_port = rd_data.client_port;
        end else begin
          result_next.status = tidr_pkg::STATUS_DROPPED;
        end
      end
      default: result_next = '0;
    endcase
  end

  // Sequencer, handshake outputs and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_query) begin
              done   <= 1'b1;
              result <= result_next;
            end else begin
              state         <= ST_LOOKUP;
              busy          <= 1'b1;
              resp_ident    <= request.txn_ident;
              resp_in_range <= in_range;
              resp_written  <= written;
            end
          end
        end
        ST_LOOKUP: begin
          state  <= ST_IDLE;
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= result_next;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/tidr_slot_ram.sv */
// Slot table storage: one write port, one read port, registered read data.
// Depends on tidr_pkg.
module tidr_slot_ram (
  input  logic                 clk,
  input  tidr_pkg::ram_wr_t    wr,
  input  logic                 rd_en,
  input  tidr_pkg::slot_idx_t  rd_addr,
  output tidr_pkg::entry_t     rd_data
);

  tidr_pkg::entry_t mem [tidr_pkg::USED_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/tidr_alloc.sv */
// Round-robin slot allocator and first-pass fill tracking.
// Depends on tidr_pkg.
module tidr_alloc (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  output tidr_pkg::alloc_t  alloc
);

  localparam tidr_pkg::slot_idx_t LAST_SLOT =
    tidr_pkg::SLOT_W'(tidr_pkg::USED_SLOTS - 1);

  tidr_pkg::slot_idx_t slot;
  logic                wrapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
    end else if (advance) begin
      if (slot == LAST_SLOT) begin
        slot    <= '0;
        wrapped <= 1'b1;
      end else begin
        slot <= slot + tidr_pkg::SLOT_W'(1);
      end
    end
  end

  assign alloc.slot    = slot;
  assign alloc.wrapped = wrapped;

endmodule

/* rtl/core/tidr_checker.sv */
// Port-level checks for the transaction ident remap table, bound to the top.
// Depends on tidr_pkg and transaction_id_remap_table_assert.svh.
`include "transaction_id_remap_table_assert.svh"

module tidr_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input tidr_pkg::request_t  request,
  input logic                done,
  input tidr_pkg::result_t   result
);

  logic acc_query;
  logic acc_resp;

  assign acc_query = start && !busy && (request.req_type == tidr_pkg::REQ_QUERY);
  assign acc_resp  = start && !busy && (request.req_type == tidr_pkg::REQ_RESPONSE);

  // Every result traces back to a transaction taken or one in progress.
  `TIDR_ASSERT_NOW(a_done_has_source, done, $past(start && !busy) || $past(busy), "orphan result")

  // A query is forwarded in the very next cycle.
  `TIDR_ASSERT_NEXT(a_query_forwarded, acc_query, done && (result.status == tidr_pkg::STATUS_FORWARDED), "query result missing or wrong status")

  // A response holds the block busy in its lookup state with no result out.
  `TIDR_ASSERT_NEXT(a_resp_lookup, acc_resp, busy && !done, "response lookup cycle missing")

  // A dropped response carries no ident or destination.
  `TIDR_ASSERT_NOW(a_drop_zero, done && (result.status == tidr_pkg::STATUS_DROPPED), (result.ident_out == '0) && (result.dest_addr == '0) && (result.dest_port == '0), "dropped response has payload")

endmodule

bind transaction_id_remap_table tidr_checker u_tidr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
